// ===== hdl/acfr_pkg.sv =====
package acfr_pkg;

	localparam int RX_BUF_DEPTH = 32;
	localparam int WP_W = $clog2(RX_BUF_DEPTH);
	localparam int IDX_W = 5;
	localparam int IDX_EXT_W = (WP_W > IDX_W) ? WP_W : IDX_W;
	localparam logic [WP_W-1:0] WP_LAST = WP_W'(RX_BUF_DEPTH - 1);

	localparam int APB_AW = 4;

	localparam logic [7:0] START_A_RST = 8'h06;
	localparam logic [7:0] START_B_RST = 8'h05;
	localparam logic [7:0] END_A_RST = 8'h03;
	localparam logic [7:0] END_B_RST = 8'h04;

	localparam logic [7:0] CHR_NINE = 8'h39;
	localparam logic [7:0] CHR_ZERO = 8'h30;
	localparam logic [7:0] CHR_SEVEN = 8'h37;

	typedef enum logic [1:0] {
		REG_START_A = 2'd0,
		REG_START_B = 2'd1,
		REG_END_A = 2'd2,
		REG_END_B = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		PH_HUNT = 3'd0,
		PH_BODY = 3'd1,
		PH_HIGH = 3'd2,
		PH_LOW = 3'd3,
		PH_GOOD = 3'd4
	} phase_t;

	typedef struct packed {
		logic [7:0] start_a;
		logic [7:0] start_b;
		logic [7:0] end_a;
		logic [7:0] end_b;
	} cfg_t;

	function automatic logic [7:0] hex_digit(input logic [7:0] c);
		return (c <= CHR_NINE) ? c - CHR_ZERO : c - CHR_SEVEN;
	endfunction

endpackage

// ===== hdl/acfr_if.sv =====
interface acfr_in_if;
	logic valid;
	logic ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface acfr_out_if;
	logic valid;
	logic ready;
	logic [2:0] frame_phase;
	logic [4:0] store_index;
	logic [7:0] store_value;
	logic store_enable;
	logic clear_last_entry;
	logic frame_good;
	logic checksum_error;

	modport source (
		output valid, output frame_phase, output store_index, output store_value,
		output store_enable, output clear_last_entry, output frame_good,
		output checksum_error, input ready
	);
	modport sink (
		input valid, input frame_phase, input store_index, input store_value,
		input store_enable, input clear_last_entry, input frame_good,
		input checksum_error, output ready
	);
endinterface

// ===== hdl/acfr_regs.sv =====
module acfr_regs (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [acfr_pkg::APB_AW-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	output acfr_pkg::cfg_t cfg
);

	acfr_pkg::cfg_t cfg_q;
	acfr_pkg::reg_idx_t idx;
	logic wr;

	assign pready = 1'b1;
	assign idx = acfr_pkg::reg_idx_t'(paddr[3:2]);
	assign wr = psel && penable && pwrite && pready;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_a <= acfr_pkg::START_A_RST;
			cfg_q.start_b <= acfr_pkg::START_B_RST;
			cfg_q.end_a <= acfr_pkg::END_A_RST;
			cfg_q.end_b <= acfr_pkg::END_B_RST;
		end else if (wr) begin
			case (idx)
				acfr_pkg::REG_START_A: cfg_q.start_a <= pwdata[7:0];
				acfr_pkg::REG_START_B: cfg_q.start_b <= pwdata[7:0];
				acfr_pkg::REG_END_A: cfg_q.end_a <= pwdata[7:0];
				acfr_pkg::REG_END_B: cfg_q.end_b <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			acfr_pkg::REG_START_A: prdata = {24'd0, cfg_q.start_a};
			acfr_pkg::REG_START_B: prdata = {24'd0, cfg_q.start_b};
			acfr_pkg::REG_END_A: prdata = {24'd0, cfg_q.end_a};
			acfr_pkg::REG_END_B: prdata = {24'd0, cfg_q.end_b};
			default: prdata = 32'd0;
		endcase
	end

endmodule

// ===== hdl/ascii_checksum_frame_receiver.sv =====
// latency: a result is valid in the cycle after its byte is accepted
// throughput: one byte per cycle while no result beat is held back; the frame state updates in the accept cycle
// the result register accepts a new byte while its current beat is taken
// reset: asynchronous, active low; phase goes to hunting, position and sum to
// zero, the start and end codes to their defaults, no result pending
module ascii_checksum_frame_receiver (
	input logic clk,
	input logic arst_n,
	acfr_in_if.sink rx,
	acfr_out_if.source res,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [acfr_pkg::APB_AW-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	acfr_pkg::cfg_t cfg;

	acfr_pkg::phase_t phase_q, phase_d;
	logic [acfr_pkg::WP_W-1:0] wpos_q, wpos_d, wpos_adv, idx;
	logic [7:0] sum_q, sum_d;
	logic [7:0] val, digit;
	logic clear_last, good, err;
	logic [acfr_pkg::IDX_EXT_W-1:0] idx_ext;
	logic acc;

	logic out_valid_q;
	logic [2:0] phase_o_q;
	logic [4:0] index_o_q;
	logic [7:0] value_o_q;
	logic clear_o_q, good_o_q, err_o_q;

	acfr_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	assign rx.ready = !out_valid_q || res.ready;
	assign acc = rx.valid && rx.ready;
	assign wpos_adv = (wpos_q == acfr_pkg::WP_LAST) ? '0 : wpos_q + 1'b1;
	assign digit = acfr_pkg::hex_digit(rx.rx_byte);

	always_comb begin
		phase_d = phase_q;
		wpos_d = wpos_adv;
		sum_d = sum_q;
		idx = wpos_adv;
		val = rx.rx_byte;
		clear_last = 1'b0;
		good = 1'b0;
		err = 1'b0;
		case (phase_q)
			acfr_pkg::PH_HUNT: begin
				if (rx.rx_byte == cfg.start_a || rx.rx_byte == cfg.start_b) begin
					phase_d = acfr_pkg::PH_BODY;
					wpos_d = '0;
					idx = '0;
					sum_d = rx.rx_byte;
				end
			end
			acfr_pkg::PH_BODY: begin
				sum_d = sum_q + rx.rx_byte;
				if (rx.rx_byte == cfg.end_a || rx.rx_byte == cfg.end_b) begin
					val = 8'd0;
					phase_d = acfr_pkg::PH_HIGH;
				end
			end
			acfr_pkg::PH_HIGH: begin
				val = 8'd0;
				if ({4'd0, sum_q[7:4]} == digit) begin
					phase_d = acfr_pkg::PH_LOW;
				end else begin
					phase_d = acfr_pkg::PH_HUNT;
					err = 1'b1;
				end
			end
			acfr_pkg::PH_LOW: begin
				val = 8'd0;
				clear_last = 1'b1;
				if ({4'd0, sum_q[3:0]} == digit) begin
					phase_d = acfr_pkg::PH_GOOD;
					good = 1'b1;
				end else begin
					phase_d = acfr_pkg::PH_HUNT;
					err = 1'b1;
				end
			end
			default: begin
				phase_d = acfr_pkg::PH_HUNT;
				wpos_d = '0;
			end
		endcase
	end

	assign idx_ext = acfr_pkg::IDX_EXT_W'(idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= acfr_pkg::PH_HUNT;
			wpos_q <= '0;
			sum_q <= 8'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				phase_q <= phase_d;
				wpos_q <= wpos_d;
				sum_q <= sum_d;
			end
			if (acc) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			phase_o_q <= phase_d;
			index_o_q <= idx_ext[4:0];
			value_o_q <= val;
			clear_o_q <= clear_last;
			good_o_q <= good;
			err_o_q <= err;
		end
	end

	assign res.valid = out_valid_q;
	assign res.frame_phase = phase_o_q;
	assign res.store_index = index_o_q;
	assign res.store_value = value_o_q;
	assign res.store_enable = 1'b1;
	assign res.clear_last_entry = clear_o_q;
	assign res.frame_good = good_o_q;
	assign res.checksum_error = err_o_q;

	a_good_returns_to_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && phase_q == acfr_pkg::PH_GOOD) |=> phase_q == acfr_pkg::PH_HUNT)
		else $error("good frame phase did not return to hunting");

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> res.valid)
		else $error("accepted byte produced no result");

	a_good_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.frame_good) |-> (res.frame_phase == acfr_pkg::PH_GOOD
		&& !res.checksum_error && res.clear_last_entry))
		else $error("good frame flag inconsistent with phase");

	a_error_to_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.checksum_error) |-> (res.frame_phase == acfr_pkg::PH_HUNT
		&& res.store_value == 8'd0))
		else $error("checksum error without return to hunting");

endmodule

// ===== bench/ascii_checksum_frame_receiver_tb.sv =====
`timescale 1ns / 100ps

module ascii_checksum_frame_receiver_tb;

	typedef enum int {FLAW_NONE, FLAW_HIGH, FLAW_LOW} flaw_t;

	typedef struct packed {
		acfr_pkg::phase_t phase;
		logic [acfr_pkg::IDX_W-1:0] idx;
		logic [7:0] value;
		logic wen;
		logic clr;
		logic good;
		logic err;
	} buf_write_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [acfr_pkg::APB_AW-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	acfr_in_if byte_in ();
	acfr_out_if wr_out ();

	ascii_checksum_frame_receiver DUT (
		.clk(clk),
		.arst_n(arst_n),
		.rx(byte_in.sink),
		.res(wr_out.source),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// predictor state
	logic [7:0] code_start_a, code_start_b, code_end_a, code_end_b;
	acfr_pkg::phase_t rx_phase;
	logic [acfr_pkg::WP_W-1:0] rx_pos;
	logic [7:0] rx_sum;

	buf_write_t pending_writes[$];
	logic [7:0] frame_body[$];

	int gap_pct = 0;
	int stall_pct = 0;
	int bytes_sent = 0;
	int beats_seen = 0;
	int frames_good = 0;
	int sum_errors = 0;
	int code_settings = 0;
	int mismatches = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

	function automatic logic [7:0] digit_value(input logic [7:0] c);
		return c - ((c > acfr_pkg::CHR_NINE) ? acfr_pkg::CHR_SEVEN : acfr_pkg::CHR_ZERO);
	endfunction

	function automatic logic [7:0] nibble_char(input logic [3:0] n);
		return (n < 4'd10) ? acfr_pkg::CHR_ZERO + {4'b0, n} : acfr_pkg::CHR_SEVEN + {4'b0, n};
	endfunction

	function automatic logic [7:0] wrong_char(input logic [3:0] n);
		logic [7:0] c;
		do c = 8'($urandom_range(255)); while (digit_value(c) == {4'b0, n});
		return c;
	endfunction

	function automatic buf_write_t predict_buffer_write(input logic [7:0] b);
		buf_write_t w;
		w.value = b;
		w.wen = 1'b1;
		w.clr = 1'b0;
		w.good = 1'b0;
		w.err = 1'b0;
		rx_pos = (rx_pos == acfr_pkg::WP_LAST) ? '0 : rx_pos + 1'b1;
		w.idx = acfr_pkg::IDX_W'(rx_pos);
		case (rx_phase)
			acfr_pkg::PH_HUNT: begin
				if (b == code_start_a || b == code_start_b) begin
					rx_phase = acfr_pkg::PH_BODY;
					rx_pos = '0;
					w.idx = '0;
					rx_sum = b;
				end
			end
			acfr_pkg::PH_BODY: begin
				rx_sum = rx_sum + b;
				if (b == code_end_a || b == code_end_b) begin
					w.value = 8'h00;
					rx_phase = acfr_pkg::PH_HIGH;
				end
			end
			acfr_pkg::PH_HIGH: begin
				w.value = 8'h00;
				if ({4'b0, rx_sum[7:4]} == digit_value(b)) begin
					rx_phase = acfr_pkg::PH_LOW;
				end else begin
					rx_phase = acfr_pkg::PH_HUNT;
					w.err = 1'b1;
				end
			end
			acfr_pkg::PH_LOW: begin
				w.value = 8'h00;
				w.clr = 1'b1;
				if ({4'b0, rx_sum[3:0]} == digit_value(b)) begin
					rx_phase = acfr_pkg::PH_GOOD;
					w.good = 1'b1;
				end else begin
					rx_phase = acfr_pkg::PH_HUNT;
					w.err = 1'b1;
				end
			end
			default: begin
				rx_phase = acfr_pkg::PH_HUNT;
				rx_pos = '0;
			end
		endcase
		w.phase = rx_phase;
		return w;
	endfunction

	task automatic note_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
	endtask

	task automatic check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got)
			note_mismatch(what, want, got);
	endtask

	// result beats
	always @(posedge clk) begin : result_check
		buf_write_t got, want;
		if (arst_n && wr_out.valid === 1'b1 && wr_out.ready) begin
			got.phase = acfr_pkg::phase_t'(wr_out.frame_phase);
			got.idx = wr_out.store_index;
			got.value = wr_out.store_value;
			got.wen = wr_out.store_enable;
			got.clr = wr_out.clear_last_entry;
			got.good = wr_out.frame_good;
			got.err = wr_out.checksum_error;
			beats_seen++;
			if (got.good === 1'b1)
				frames_good++;
			if (got.err === 1'b1)
				sum_errors++;
			if (pending_writes.size() == 0) begin
				note_mismatch("beat with nothing pending", '0, 32'(got));
			end else begin
				want = pending_writes.pop_front();
				check_field("frame_phase", 32'(want.phase), 32'(got.phase));
				check_field("store_index", 32'(want.idx), 32'(got.idx));
				check_field("store_value", 32'(want.value), 32'(got.value));
				check_field("store_enable", 32'(want.wen), 32'(got.wen));
				check_field("clear_last_entry", 32'(want.clr), 32'(got.clr));
				check_field("frame_good", 32'(want.good), 32'(got.good));
				check_field("checksum_error", 32'(want.err), 32'(got.err));
			end
		end
	end

	initial begin
		wr_out.ready = 1'b1;
		forever begin
			@(negedge clk);
			wr_out.ready = ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic send_byte(input logic [7:0] b);
		@(negedge clk);
		while ($urandom_range(99) < gap_pct) begin
			byte_in.valid = 1'b0;
			byte_in.rx_byte = 8'($urandom_range(255));
			@(negedge clk);
		end
		byte_in.valid = 1'b1;
		byte_in.rx_byte = b;
		do @(posedge clk); while (!byte_in.ready);
		pending_writes.push_back(predict_buffer_write(b));
		bytes_sent++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		byte_in.valid = 1'b0;
		while (pending_writes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_idling(input int gap, input int stall);
		gap_pct = gap;
		stall_pct = stall;
	endtask

	task automatic apb_access(input acfr_pkg::reg_idx_t r, input logic wr,
			input logic [31:0] wdata, output logic [31:0] rdata);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = wr;
		paddr = acfr_pkg::APB_AW'({r, 2'b00});
		pwdata = wdata;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic read_code(input acfr_pkg::reg_idx_t r, input logic [7:0] want);
		logic [31:0] rdata;
		apb_access(r, 1'b0, '0, rdata);
		check_field(r.name(), {24'b0, want}, rdata);
	endtask

	task automatic write_code(input acfr_pkg::reg_idx_t r, input logic [7:0] v);
		logic [31:0] rdata;
		apb_access(r, 1'b1, {24'b0, v}, rdata);
		case (r)
			acfr_pkg::REG_START_A: code_start_a = v;
			acfr_pkg::REG_START_B: code_start_b = v;
			acfr_pkg::REG_END_A: code_end_a = v;
			acfr_pkg::REG_END_B: code_end_b = v;
			default: ;
		endcase
		read_code(r, v);
	endtask

	task automatic send_frame(input logic [7:0] opener, input logic [7:0] closer,
			input flaw_t flaw);
		logic [7:0] sum;
		logic [7:0] hi_ch, lo_ch;
		sum = opener + closer;
		foreach (frame_body[i])
			sum = sum + frame_body[i];
		hi_ch = (flaw == FLAW_HIGH) ? wrong_char(sum[7:4]) : nibble_char(sum[7:4]);
		lo_ch = (flaw == FLAW_LOW) ? wrong_char(sum[3:0]) : nibble_char(sum[3:0]);
		send_byte(opener);
		foreach (frame_body[i])
			send_byte(frame_body[i]);
		send_byte(closer);
		send_byte(hi_ch);
		if (flaw != FLAW_HIGH)
			send_byte(lo_ch);
	endtask

	// bring the receiver back to hunting so the next frame is taken
	task automatic flush_to_hunt();
		while (rx_phase != acfr_pkg::PH_HUNT) begin
			if (rx_phase == acfr_pkg::PH_BODY)
				send_byte(code_end_a);
			else
				send_byte(8'($urandom_range(255)));
		end
	endtask

	function automatic logic [7:0] pick_start();
		return $urandom_range(1) ? code_start_b : code_start_a;
	endfunction

	task automatic run_traffic(input int n);
		int target, kind, len, sel;
		logic [7:0] b;
		flaw_t flaw;
		target = bytes_sent + n;
		while (bytes_sent < target) begin
			kind = $urandom_range(99);
			if (kind < 70) begin
				flush_to_hunt();
				len = ($urandom_range(9) == 0) ? $urandom_range(40, 20) : $urandom_range(10);
				frame_body.delete();
				repeat (len) begin
					do b = 8'($urandom_range(255)); while (b == code_end_a || b == code_end_b);
					frame_body.push_back(b);
				end
				sel = $urandom_range(9);
				flaw = (sel == 0) ? FLAW_HIGH : (sel == 1) ? FLAW_LOW : FLAW_NONE;
				send_frame(pick_start(), $urandom_range(1) ? code_end_b : code_end_a, flaw);
			end else if (kind < 85) begin
				repeat ($urandom_range(6, 1))
					send_byte(8'($urandom_range(255)));
			end else begin
				// frame cut short
				send_byte(pick_start());
				repeat ($urandom_range(5))
					send_byte(8'($urandom_range(255)));
			end
		end
	endtask

	task automatic test_reset_codes();
		read_code(acfr_pkg::REG_START_A, acfr_pkg::START_A_RST);
		read_code(acfr_pkg::REG_START_B, acfr_pkg::START_B_RST);
		read_code(acfr_pkg::REG_END_A, acfr_pkg::END_A_RST);
		read_code(acfr_pkg::REG_END_B, acfr_pkg::END_B_RST);
	endtask

	task automatic test_directed_frames();
		set_idling(0, 0);
		send_byte(8'h00);
		send_byte(8'hFF);
		frame_body = {8'h41, 8'h00, 8'hFF};
		send_frame(acfr_pkg::START_A_RST, acfr_pkg::END_A_RST, FLAW_NONE);
		// start code while a good frame waits only returns to hunting
		send_byte(acfr_pkg::START_A_RST);
		frame_body.delete();
		send_frame(acfr_pkg::START_B_RST, acfr_pkg::END_B_RST, FLAW_NONE);
		send_byte(8'h55);
		frame_body = {8'h78};
		send_frame(acfr_pkg::START_A_RST, acfr_pkg::END_A_RST, FLAW_HIGH);
		frame_body = {8'h79};
		send_frame(acfr_pkg::START_B_RST, acfr_pkg::END_B_RST, FLAW_LOW);
		wait_drained();
	endtask

	task automatic test_idling_phases();
		set_idling(0, 0);
		run_traffic(90);
		set_idling(70, 0);
		run_traffic(90);
		set_idling(0, 70);
		run_traffic(90);
		set_idling(8, 8);
		run_traffic(90);
		wait_drained();
	endtask

	task automatic apply_codes(input logic [7:0] sa, input logic [7:0] sb, input logic [7:0] ea,
			input logic [7:0] eb);
		wait_drained();
		write_code(acfr_pkg::REG_START_A, sa);
		write_code(acfr_pkg::REG_START_B, sb);
		write_code(acfr_pkg::REG_END_A, ea);
		write_code(acfr_pkg::REG_END_B, eb);
		code_settings++;
		run_traffic(30);
	endtask

	task automatic test_code_settings();
		set_idling(8, 8);
		apply_codes(8'h00, 8'hFF, 8'h00, 8'hFF);
		apply_codes(8'hFF, 8'hFF, 8'h00, 8'h00);
		apply_codes(8'($urandom_range(255)), 8'($urandom_range(255)),
			8'($urandom_range(255)), 8'($urandom_range(255)));
		apply_codes(acfr_pkg::START_A_RST, acfr_pkg::START_B_RST, acfr_pkg::END_A_RST,
			acfr_pkg::END_B_RST);
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		byte_in.valid = 1'b0;
		byte_in.rx_byte = 8'h00;
		code_start_a = acfr_pkg::START_A_RST;
		code_start_b = acfr_pkg::START_B_RST;
		code_end_a = acfr_pkg::END_A_RST;
		code_end_b = acfr_pkg::END_B_RST;
		rx_phase = acfr_pkg::PH_HUNT;
		rx_pos = '0;
		rx_sum = 8'h00;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_codes();
		test_directed_frames();
		test_idling_phases();
		test_code_settings();

		$display("%0d bytes sent, %0d result beats checked, %0d mismatches",
			bytes_sent, beats_seen, mismatches);
		$display("%0d good frames, %0d checksum errors, %0d start/end code settings",
			frames_good, sum_errors, code_settings);
		if (mismatches == 0 && pending_writes.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ===== ascii_checksum_frame_receiver.f =====
hdl/acfr_pkg.sv
hdl/acfr_if.sv
hdl/acfr_regs.sv
hdl/ascii_checksum_frame_receiver.sv
bench/ascii_checksum_frame_receiver_tb.sv
